// ----- hw/rtl/tasp_pkg.sv -----
// Shared types, constants and the speed-to-period table for the step pulse generator.
// No dependencies; every other file in hw/rtl imports this package.
package tasp_pkg;

  // Number of axes and the fixed field widths of the channels.
  localparam int AXES        = 3;
  localparam int LEVELS_W    = 3;
  localparam int AXIS_W      = 2;
  localparam int STEP_CNT_W  = 31;
  localparam int EDGE_W      = 32;
  localparam int PRESCALE_W  = 10;
  localparam int SPEED_W     = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  // Step period bounds in microseconds and the tick length.
  localparam int SLOWEST_PERIOD_US = 10000;
  localparam int FASTEST_PERIOD_US = 500;
  localparam int TICK_US           = 10;
  localparam int PERCENT_FULL      = 100;

  // Legal speed range and the speed after reset.
  localparam logic [SPEED_W-1:0] SPEED_MIN   = SPEED_W'(1);
  localparam logic [SPEED_W-1:0] SPEED_MAX   = SPEED_W'(100);
  localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(50);

  // Item kinds.
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_MOVE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b1;

  localparam int SPEED_LEVELS = 2 ** SPEED_W;
  localparam int PERIOD_MAX   = 2 ** PRESCALE_W - 1;

  typedef logic [PRESCALE_W-1:0] period_tab_t [SPEED_LEVELS];

  // Command from the top level to one axis.
  typedef struct packed {
    logic              load;
    logic              dir;
    logic [EDGE_W-1:0] target;
    logic              wrap;
  } axis_cmd_t;

  // Pin levels of one axis after the current word.
  typedef struct packed {
    logic step;
    logic dir;
    logic moving;
  } axis_status_t;

  // Prescaler period for every speed code, worked out at elaboration.
  function automatic period_tab_t build_period_table();
    period_tab_t tab;
    int          p;
    for (int s = 0; s < SPEED_LEVELS; s++) begin
      p = FASTEST_PERIOD_US +
          ((SLOWEST_PERIOD_US - FASTEST_PERIOD_US) * (PERCENT_FULL - s)) / PERCENT_FULL;
      p = p / TICK_US;
      if (p < 0) p = 0;
      if (p > PERIOD_MAX) p = PERIOD_MAX;
      tab[s] = PRESCALE_W'(p);
    end
    return tab;
  endfunction

  localparam period_tab_t PERIOD_TABLE = build_period_table();

endpackage

// ----- hw/rtl/three_axis_step_pulse_generator.sv -----
// Top level of the three-axis step pulse generator: input register, prescaler, axes,
// result register. Depends on tasp_pkg, tasp_cfg and tasp_axis.
//
//   Channel  Ports                                         Direction  Moves per word
//   in       in_valid/in_stall, action axis dir steps      input      one tick or move
//   out      out_valid/out_stall, step dir moving enable   output     pin levels
//   cfg      cfg_we, cfg_index, cfg_wdata                  input      one register write
//
// Each word passes through the input register; then the prescaler and all axes update in
// parallel and the levels land in the result register.
// A new word is accepted every cycle unless the result side stalls; the axis update never holds the flow.
// Reset is synchronous and active low; it clears all axis state and the prescaler.
// A stall on the result side holds the result register and then the input register.
module three_axis_step_pulse_generator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_action,
  input  logic [tasp_pkg::AXIS_W-1:0]        in_axis,
  input  logic                               in_direction,
  input  logic [tasp_pkg::STEP_CNT_W-1:0]    in_step_count,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tasp_pkg::LEVELS_W-1:0]      out_step_levels,
  output logic [tasp_pkg::LEVELS_W-1:0]      out_direction_levels,
  output logic [tasp_pkg::LEVELS_W-1:0]      out_moving_mask,
  output logic                               out_drivers_enabled,
  input  logic                               cfg_we,
  input  logic [tasp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tasp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tasp_pkg::*;

  logic                  in_valid_r, in_valid_nxt;
  logic                  action_r;
  logic [AXIS_W-1:0]     axis_r;
  logic                  dir_r;
  logic [STEP_CNT_W-1:0] steps_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [LEVELS_W-1:0]   step_levels_r, dir_levels_r, moving_r;
  logic                  enabled_r;
  logic [PRESCALE_W-1:0] prescale_r, prescale_nxt;
  logic [PRESCALE_W-1:0] period;
  logic                  drivers_enable;
  logic                  advance, in_accept, tick, wrap;
  logic [LEVELS_W-1:0]   step_nxt, dir_nxt, moving_nxt;
  axis_cmd_t             cmd    [AXES];
  axis_status_t          status [AXES];

  tasp_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .period         (period),
    .drivers_enable (drivers_enable)
  );

  // Handshake: the held word moves on when the result register is free or being taken.
  assign advance      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall     = in_valid_r && !advance;
  assign in_accept    = in_valid && !in_stall;
  assign in_valid_nxt = in_accept || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      action_r <= in_action;
      axis_r   <= in_axis;
      dir_r    <= in_direction;
      steps_r  <= in_step_count;
    end
  end

  // Shared prescaler: counts ticks up to the period, then wraps and steps the axes.
  assign tick = advance && (action_r == ACT_TICK);
  assign wrap = tick && !(prescale_r < period);

  always_comb begin
    prescale_nxt = prescale_r;
    if (tick) begin
      if (wrap) prescale_nxt = '0;
      else      prescale_nxt = prescale_r + PRESCALE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) prescale_r <= '0;
    else        prescale_r <= prescale_nxt;
  end

  // Axis lanes; a move for an axis that does not exist reaches none of them.
  for (genvar a = 0; a < AXES; a++) begin : g_axis
    assign cmd[a].load   = advance && (action_r == ACT_MOVE) && (axis_r == AXIS_W'(a));
    assign cmd[a].dir    = dir_r;
    assign cmd[a].target = {steps_r, 1'b0};
    assign cmd[a].wrap   = wrap;

    tasp_axis u_axis (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd[a]),
      .status_nxt (status[a])
    );
  end

  // Gather the per-axis levels into the result bit vectors.
  for (genvar b = 0; b < LEVELS_W; b++) begin : g_levels
    if (b < AXES) begin : g_used
      assign step_nxt[b]   = status[b].step;
      assign dir_nxt[b]    = status[b].dir;
      assign moving_nxt[b] = status[b].moving;
    end else begin : g_unused
      assign step_nxt[b]   = 1'b0;
      assign dir_nxt[b]    = 1'b0;
      assign moving_nxt[b] = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (advance) begin
      step_levels_r <= step_nxt;
      dir_levels_r  <= dir_nxt;
      moving_r      <= moving_nxt;
      enabled_r     <= drivers_enable;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_step_levels      = step_levels_r;
  assign out_direction_levels = dir_levels_r;
  assign out_moving_mask      = moving_r;
  assign out_drivers_enabled  = enabled_r;

endmodule

// ----- hw/rtl/tasp_cfg.sv -----
// Configuration registers: speed percent with its registered prescaler period, driver enable.
// Depends on tasp_pkg.
module tasp_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tasp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tasp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic [tasp_pkg::PRESCALE_W-1:0]   period,
  output logic                              drivers_enable
);
  import tasp_pkg::*;

  logic [PRESCALE_W-1:0] period_r, period_nxt;
  logic                  enable_r, enable_nxt;
  logic [SPEED_W-1:0]    speed_in;

  assign speed_in = cfg_wdata[SPEED_W-1:0];

  // A speed write outside the legal range leaves the period unchanged.
  always_comb begin
    period_nxt = period_r;
    enable_nxt = enable_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED: begin
          if (speed_in inside {[SPEED_MIN:SPEED_MAX]}) period_nxt = PERIOD_TABLE[speed_in];
        end
        CFG_ENABLE: begin
          enable_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_TABLE[SPEED_RESET];
      enable_r <= 1'b0;
    end else begin
      period_r <= period_nxt;
      enable_r <= enable_nxt;
    end
  end

  assign period         = period_r;
  assign drivers_enable = enable_r;

endmodule

// ----- hw/rtl/tasp_axis.sv -----
// One axis: edge counter, edge target, step toggle and direction level.
// Depends on tasp_pkg.
module tasp_axis (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tasp_pkg::axis_cmd_t     cmd,
  output tasp_pkg::axis_status_t  status_nxt
);
  import tasp_pkg::*;

  logic [EDGE_W-1:0] count_r, count_nxt;
  logic [EDGE_W-1:0] target_r, target_nxt;
  logic              toggle_r, toggle_nxt;
  logic              step_r, step_nxt;
  logic              moving_r, moving_nxt;
  logic              dir_r, dir_nxt;

  // A move command restarts the axis; a prescaler wrap makes one edge or stops it.
  always_comb begin
    count_nxt  = count_r;
    target_nxt = target_r;
    toggle_nxt = toggle_r;
    step_nxt   = step_r;
    moving_nxt = moving_r;
    dir_nxt    = dir_r;
    if (cmd.load) begin
      dir_nxt    = cmd.dir;
      target_nxt = cmd.target;
      count_nxt  = '0;
      moving_nxt = 1'b1;
    end else if (cmd.wrap && moving_r) begin
      if (count_r < target_r) begin
        count_nxt  = count_r + EDGE_W'(1);
        step_nxt   = toggle_r;
        toggle_nxt = ~toggle_r;
      end else begin
        moving_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      target_r <= '0;
      toggle_r <= 1'b0;
      step_r   <= 1'b0;
      moving_r <= 1'b0;
      dir_r    <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      target_r <= target_nxt;
      toggle_r <= toggle_nxt;
      step_r   <= step_nxt;
      moving_r <= moving_nxt;
      dir_r    <= dir_nxt;
    end
  end

  // The result word reports levels after this item.
  assign status_nxt.step   = step_nxt;
  assign status_nxt.dir    = dir_nxt;
  assign status_nxt.moving = moving_nxt;

endmodule

// ----- hw/rtl/tasp_checker.sv -----
// Port-level checks for the step pulse generator, bound to its top level.
// Depends on tasp_pkg and three_axis_step_pulse_generator.
module tasp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [tasp_pkg::LEVELS_W-1:0]      out_step_levels,
  input logic [tasp_pkg::LEVELS_W-1:0]      out_direction_levels,
  input logic [tasp_pkg::LEVELS_W-1:0]      out_moving_mask,
  input logic                               out_drivers_enabled
);
  import tasp_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_step_levels) &&
    $stable(out_direction_levels) && $stable(out_moving_mask) && $stable(out_drivers_enabled))
    else $error("stalled result word changed");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The input side only backs up behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // After an accepted word has passed the input register, the result register holds a valid word.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("no result two cycles after an accepted word");

endmodule

bind three_axis_step_pulse_generator tasp_checker u_tasp_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_step_levels      (out_step_levels),
  .out_direction_levels (out_direction_levels),
  .out_moving_mask      (out_moving_mask),
  .out_drivers_enabled  (out_drivers_enabled)
);
